@@ rtl/c2d_pkg.sv @@
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types, codes and sizes of the 2-D convolution unit.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // Store sizes
  localparam int MAX_IMAGE_ROWS  = 64;
  localparam int MAX_IMAGE_COLS  = 64;
  localparam int MAX_KERNEL_ROWS = 8;
  localparam int MAX_KERNEL_COLS = 8;

  localparam int IMG_ROW_W   = $clog2(MAX_IMAGE_ROWS);
  localparam int IMG_COL_W   = $clog2(MAX_IMAGE_COLS);
  localparam int KER_ROW_W   = $clog2(MAX_KERNEL_ROWS);
  localparam int KER_COL_W   = $clog2(MAX_KERNEL_COLS);
  localparam int IMG_ADDR_W  = IMG_ROW_W + IMG_COL_W;
  localparam int KER_ADDR_W  = KER_ROW_W + KER_COL_W;
  localparam int IMG_DEPTH   = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
  localparam int KER_DEPTH   = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int RESULT_W = 32;
  localparam int ACC_W    = PROD_W + KER_ROW_W + KER_COL_W + 1;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 3;

  // Item modes
  localparam logic [1:0] MODE_KERNEL  = 2'd0;
  localparam logic [1:0] MODE_IMAGE   = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORRELATE   = 3'd5;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [6:0]                 row_index;
    logic [6:0]                 col_index;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic                       out_of_range;
  } out_word_t;

  // Sizes in use, already clamped to their legal ranges
  typedef struct packed {
    logic [6:0] image_rows;
    logic [6:0] image_cols;
    logic [3:0] kernel_rows;
    logic [3:0] kernel_cols;
    logic       same_size;
    logic       correlate;
  } cfg_t;

  typedef struct packed {
    logic wr_kernel;
    logic wr_image;
    logic start;
    logic setup;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic last_tap;
    logic out_busy;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [6:0] clamp_size(input logic [6:0] v, input logic [6:0] maxv);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

@@ rtl/c2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// c2d_ctrl
// Sequencer: takes input words, runs the tap walk of a request through the
// datapath, drains the multiply-accumulate pipe and hands off the result.
// ----------------------------------------------------------------------------
module c2d_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  output logic          in_ready,
  input  c2d_pkg::sts_t sts,
  output c2d_pkg::cmd_t cmd
);
  import c2d_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.wr_kernel = in_valid && (in_mode == MODE_KERNEL);
        cmd.wr_image  = in_valid && (in_mode == MODE_IMAGE);
        cmd.start     = in_valid && (in_mode == MODE_REQUEST);
        if (cmd.start) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.oor) state_next = ST_FINISH;
        else state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_tap) state_next = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        state_next = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_req_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_REQUEST) |=> !in_ready)
    else $error("input taken while a request is in progress");

  a_oor_skips: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP) && sts.oor |=> state == ST_FINISH)
    else $error("out-of-range request walked the taps");

  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready && !cmd.emit)
    else $error("tap walk overlaps input or result handoff");

endmodule

@@ rtl/c2d_datapath.sv @@
// ----------------------------------------------------------------------------
// c2d_datapath
// Image and kernel stores, tap counters, address generation, one shared
// multiply-accumulate pipe, saturation and the output register.
// ----------------------------------------------------------------------------
module c2d_datapath (
  input  logic               clk,
  input  logic               rst,
  input  c2d_pkg::cfg_t      cfg,
  input  c2d_pkg::in_word_t  in_data,
  input  c2d_pkg::cmd_t      cmd,
  output c2d_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output c2d_pkg::out_word_t out_data
);
  import c2d_pkg::*;

  // Stores
  logic signed [SAMPLE_W-1:0] image_mem  [IMG_DEPTH];
  logic signed [SAMPLE_W-1:0] kernel_mem [KER_DEPTH];

  // Request registers
  logic [6:0]           req_row;
  logic [6:0]           req_col;
  logic [7:0]           pos_i;
  logic [7:0]           pos_j;
  logic                 oor_flag;
  logic [KER_ROW_W-1:0] tap_m;
  logic [KER_COL_W-1:0] tap_n;

  // Pipe
  logic                       v1;
  logic                       v2;
  logic signed [SAMPLE_W-1:0] img_rd;
  logic signed [SAMPLE_W-1:0] ker_rd;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // Combinational helpers
  logic [7:0]            off_i;
  logic [7:0]            off_j;
  logic [7:0]            lim_r;
  logic [7:0]            lim_c;
  logic                  oor_now;
  logic [8:0]            dif_r;
  logic [8:0]            dif_c;
  logic                  tap_in;
  logic [3:0]            km_full;
  logic [3:0]            kn_full;
  logic [KER_ROW_W-1:0]  km;
  logic [KER_COL_W-1:0]  kn;
  logic [IMG_ADDR_W-1:0] img_addr;
  logic [KER_ADDR_W-1:0] ker_addr;
  logic                  last_n;
  logic                  last_m;
  logic signed [RESULT_W-1:0] sat_val;

  // Output position bounds and same-mode offset
  always_comb begin
    if (cfg.same_size) begin
      off_i = 8'(req_row) + 8'(cfg.kernel_rows >> 1);
      off_j = 8'(req_col) + 8'(cfg.kernel_cols >> 1);
      lim_r = 8'(cfg.image_rows);
      lim_c = 8'(cfg.image_cols);
    end else begin
      off_i = 8'(req_row);
      off_j = 8'(req_col);
      lim_r = 8'(cfg.image_rows) + 8'(cfg.kernel_rows) - 8'd1;
      lim_c = 8'(cfg.image_cols) + 8'(cfg.kernel_cols) - 8'd1;
    end
    oor_now = (8'(req_row) >= lim_r) || (8'(req_col) >= lim_c);
  end

  // Tap address generation
  always_comb begin
    dif_r    = {1'b0, pos_i} - 9'(tap_m);
    dif_c    = {1'b0, pos_j} - 9'(tap_n);
    tap_in   = !dif_r[8] && (dif_r[7:0] < 8'(cfg.image_rows)) &&
               !dif_c[8] && (dif_c[7:0] < 8'(cfg.image_cols));
    km_full  = cfg.correlate ? (cfg.kernel_rows - 4'd1 - 4'(tap_m)) : 4'(tap_m);
    kn_full  = cfg.correlate ? (cfg.kernel_cols - 4'd1 - 4'(tap_n)) : 4'(tap_n);
    km       = km_full[KER_ROW_W-1:0];
    kn       = kn_full[KER_COL_W-1:0];
    img_addr = {dif_r[IMG_ROW_W-1:0], dif_c[IMG_COL_W-1:0]};
    ker_addr = {km, kn};
    last_n   = (4'(tap_n) == cfg.kernel_cols - 4'd1);
    last_m   = (4'(tap_m) == cfg.kernel_rows - 4'd1);
  end

  assign sts.oor      = oor_now;
  assign sts.last_tap = last_n && last_m;
  assign sts.out_busy = out_valid && !out_ready;

  // Store writes
  always_ff @(posedge clk) begin
    if (cmd.wr_kernel && (in_data.row_index < 7'(MAX_KERNEL_ROWS)) &&
        (in_data.col_index < 7'(MAX_KERNEL_COLS))) begin
      kernel_mem[{in_data.row_index[KER_ROW_W-1:0],
                  in_data.col_index[KER_COL_W-1:0]}] <= in_data.sample;
    end
    if (cmd.wr_image && (in_data.row_index < 7'(MAX_IMAGE_ROWS)) &&
        (in_data.col_index < 7'(MAX_IMAGE_COLS))) begin
      image_mem[{in_data.row_index[IMG_ROW_W-1:0],
                 in_data.col_index[IMG_COL_W-1:0]}] <= in_data.sample;
    end
  end

  // Store reads, one tap per cycle
  always_ff @(posedge clk) begin
    img_rd <= image_mem[img_addr];
    ker_rd <= kernel_mem[ker_addr];
  end

  // Latch request, set up position, advance tap counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_row <= in_data.row_index;
      req_col <= in_data.col_index;
    end
    if (cmd.setup) begin
      pos_i    <= off_i;
      pos_j    <= off_j;
      oor_flag <= oor_now;
      tap_m    <= '0;
      tap_n    <= '0;
    end else if (cmd.step) begin
      if (last_n) begin
        tap_n <= '0;
        tap_m <= tap_m + 1'b1;
      end else begin
        tap_n <= tap_n + 1'b1;
      end
    end
  end

  // Multiply-accumulate pipe
  always_ff @(posedge clk) begin
    prod <= img_rd * ker_rd;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.step && tap_in;
      v2 <= v1;
    end
    if (cmd.setup) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Saturate to 32 bits
  always_comb begin
    if (acc[ACC_W-1:RESULT_W-1] == '0 || acc[ACC_W-1:RESULT_W-1] == '1) begin
      sat_val = acc[RESULT_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat_val = {1'b1, {(RESULT_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(RESULT_W-1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data.out_of_range <= oor_flag;
      out_data.result_value <= oor_flag ? '0 : sat_val;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwrote an untaken word");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_of_range |-> out_data.result_value == '0)
    else $error("out-of-range result carries a value");

  a_pipe_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !v1 && !v2)
    else $error("result taken before the pipe drained");

endmodule

@@ rtl/conv2d_full_same_correlate_unit.sv @@
// ----------------------------------------------------------------------------
// conv2d_full_same_correlate_unit
// Two-dimensional convolution / correlation engine, full or same output size.
// ----------------------------------------------------------------------------
// Loads of kernel coefficients and image samples give no word out. A request
// goes from acceptance through setup, a walk over all kernel_rows *
// kernel_cols taps and the pipe drain to a finish state; an out-of-range
// request skips from setup to finish. The single multiply-accumulate pipe
// walks one kernel tap per cycle against one read port on each store. A
// finished word waits in the output register while loads go on. Image samples
// outside the image in use read as zero; store entries that will be read must
// be written first. Registers are to be written through the configuration
// port only while the unit is idle, which the unit itself does not enforce.
// ----------------------------------------------------------------------------
module conv2d_full_same_correlate_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  c2d_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output c2d_pkg::out_word_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c2d_pkg::CFG_W-1:0]        cfg_data
);
  import c2d_pkg::*;

  logic [6:0] image_rows;
  logic [6:0] image_cols;
  logic [3:0] kernel_rows;
  logic [3:0] kernel_cols;
  logic       same_size;
  logic       correlate;
  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= 7'd64;
      image_cols  <= 7'd64;
      kernel_rows <= 4'd3;
      kernel_cols <= 4'd3;
      same_size   <= 1'b0;
      correlate   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        REG_IMAGE_COLS:  image_cols  <= cfg_data;
        REG_KERNEL_ROWS: kernel_rows <= cfg_data[3:0];
        REG_KERNEL_COLS: kernel_cols <= cfg_data[3:0];
        REG_SAME_SIZE:   same_size   <= cfg_data[0];
        REG_CORRELATE:   correlate   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store limits
  always_comb begin
    cfg.image_rows  = clamp_size(image_rows, 7'(MAX_IMAGE_ROWS));
    cfg.image_cols  = clamp_size(image_cols, 7'(MAX_IMAGE_COLS));
    cfg.kernel_rows = 4'(clamp_size(7'(kernel_rows), 7'(MAX_KERNEL_ROWS)));
    cfg.kernel_cols = 4'(clamp_size(7'(kernel_cols), 7'(MAX_KERNEL_COLS)));
    cfg.same_size   = same_size;
    cfg.correlate   = correlate;
  end

  c2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  c2d_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
